FILE: src/rau_pkg.sv
`timescale 1ns / 1ps
// Package: opcodes and payload types for the rational arithmetic unit.
package rau_pkg;

  localparam int OpW  = 3;
  localparam int NumW = 33;
  localparam int DenW = 32;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_GT  = 3'd5,
    OP_LT  = 3'd6,
    OP_NOP = 3'd7
  } op_t;

  // Classified work handed from the front to the back.
  typedef struct packed {
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
    logic            arith;
    logic            cmp;
  } work_t;

  typedef struct packed {
    logic [NumW-1:0] result_num;
    logic [DenW-1:0] result_den;
    logic            compare_true;
    logic            zero_divisor;
  } out_item_t;

endpackage

FILE: src/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// Top level: rational arithmetic unit with GCD reduction.
// A transaction passes the front (accept, two multiply steps, output) and, in the back,
// goes straight out for compares and zero cases, else through Euclid steps, each a
// bit-serial remainder, and then the two exact divisions.
// The shared bit-serial divider in the back sets the rate; a two-entry queue
// lets the front classify the next transaction meanwhile.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [OpW+4*OPERAND_WIDTH-1:0] in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int W = OPERAND_WIDTH;

  logic  fq_valid, fq_stall, qb_valid, qb_stall;
  work_t fq_data, qb_data;

  rau_front #(.W(W)) u_front (
    .clk, .rst, .in_valid, .in_stall,
    .op_in (in_item[4*W +: OpW]),
    .an    (in_item[3*W +: W]),
    .ad    (in_item[2*W +: W]),
    .bn    (in_item[W +: W]),
    .bd    (in_item[0 +: W]),
    .wk_valid (fq_valid), .wk_stall (fq_stall), .wk (fq_data)
  );

  rau_queue u_queue (
    .clk, .rst,
    .wr_valid (fq_valid), .wr_stall (fq_stall), .wr_data (fq_data),
    .rd_valid (qb_valid), .rd_stall (qb_stall), .rd_data (qb_data)
  );

  rau_back u_back (
    .clk, .rst,
    .wk_valid (qb_valid), .wk_stall (qb_stall), .wk (qb_data),
    .out_valid, .out_stall, .out_item
  );

endmodule

FILE: src/rau_front.sv
`timescale 1ns / 1ps
// Front: accepts a transaction, forms the cross products and classifies it.
module rau_front
  import rau_pkg::*;
#(
  parameter int W = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [OpW-1:0] op_in,
  input  logic [W-1:0]  an,
  input  logic [W-1:0]  ad,
  input  logic [W-1:0]  bn,
  input  logic [W-1:0]  bd,
  output logic          wk_valid,
  input  logic          wk_stall,
  output work_t         wk
);

  typedef enum logic [1:0] {S_IDLE, S_MUL1, S_MUL2, S_OUT} state_t;

  state_t         state;
  op_t            op;
  logic [W-1:0]   ran, rad, rbn, rbd;
  logic [2*W-1:0] left, right;
  logic [2*W-1:0] p_a, p_b;
  logic [1:0]     step;

  // One product of each pair a cycle: step 0 cross terms, then step 1 num/den.
  always_comb begin
    if (step != 2'd0) begin
      p_a = (2*W)'(ran) * (2*W)'(rbn);
      p_b = (2*W)'(rad) * (2*W)'(op == OP_DIV ? rbn : rbd);
    end else begin
      p_a = (2*W)'(ran) * (2*W)'(rbd);
      p_b = (2*W)'(rbn) * (2*W)'(rad);
    end
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wk_valid <= 1'b0;
      step     <= 2'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= op_t'(op_in);
            ran   <= an;
            rad   <= ad;
            rbn   <= bn;
            rbd   <= bd;
            step  <= 2'd0;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          left  <= p_a;
          right <= p_b;
          step  <= 2'd1;
          state <= S_MUL2;
        end
        S_MUL2: begin
          case (op)
            OP_ADD: begin
              wk.arith <= 1'b1;
              wk.cmp   <= 1'b0;
              wk.num   <= NumW'(left) + NumW'(right);
              wk.den   <= DenW'(p_b);
            end
            OP_SUB: begin
              wk.arith <= 1'b1;
              wk.cmp   <= 1'b0;
              wk.num   <= (left > right) ? NumW'(left - right) : '0;
              wk.den   <= DenW'(p_b);
            end
            OP_MUL: begin
              wk.arith <= 1'b1;
              wk.cmp   <= 1'b0;
              wk.num   <= NumW'(p_a);
              wk.den   <= DenW'(p_b);
            end
            OP_DIV: begin
              wk.arith <= 1'b1;
              wk.cmp   <= 1'b0;
              wk.num   <= NumW'(left);
              wk.den   <= DenW'(p_b);
            end
            OP_EQ: begin
              wk.arith <= 1'b0;
              wk.cmp   <= (ran == rbn) && (rad == rbd);
              wk.num   <= '0;
              wk.den   <= '0;
            end
            OP_GT: begin
              wk.arith <= 1'b0;
              wk.cmp   <= left > right;
              wk.num   <= '0;
              wk.den   <= '0;
            end
            OP_LT: begin
              wk.arith <= 1'b0;
              wk.cmp   <= left < right;
              wk.num   <= '0;
              wk.den   <= '0;
            end
            default: begin
              wk.arith <= 1'b0;
              wk.cmp   <= 1'b0;
              wk.num   <= '0;
              wk.den   <= '0;
            end
          endcase
          wk_valid <= 1'b1;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (!wk_stall) begin
            wk_valid <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/rau_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between the front and the back.
module rau_queue
  import rau_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_stall,
  input  work_t wr_data,
  output logic  rd_valid,
  input  logic  rd_stall,
  output work_t rd_data
);

  work_t      mem [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       push, pop;

  assign wr_stall = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rp];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: src/rau_back.sv
`timescale 1ns / 1ps
// Back: Euclid GCD by restoring remainder, then two exact divisions, bit serial.
module rau_back
  import rau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wk_valid,
  output logic      wk_stall,
  input  work_t     wk,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CntW = $clog2(NumW + 1);

  typedef enum logic [2:0] {S_IDLE, S_GCD, S_DIVN, S_DIVD, S_OUT} state_t;

  state_t          state;
  logic [NumW-1:0] n, d;      // saved operands
  logic [NumW-1:0] x, y;      // Euclid pair
  logic [NumW-1:0] rem, quo;  // divider work
  logic [CntW-1:0] cnt;
  logic [NumW:0]   trial;
  logic [NumW-1:0] rsh;
  logic            do_mod;    // in GCD: divider computes x mod y

  // One restoring-division step: divisor is y.
  always_comb begin
    rsh   = {rem[NumW-2:0], quo[NumW-1]};
    trial = {1'b0, rsh} - {1'b0, y};
  end

  assign wk_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      do_mod    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (wk_valid) begin
            n <= wk.num;
            d <= NumW'(wk.den);
            out_item.compare_true <= wk.cmp;
            out_item.zero_divisor <= wk.arith && (wk.den == '0);
            out_item.result_num   <= wk.num;
            // zero numerator over a nonzero denominator reads as 0/1
            out_item.result_den   <= (wk.arith && wk.den != '0 && wk.num == '0) ?
                                     DenW'(1) : wk.den;
            if (!wk.arith || wk.den == '0 || wk.num == '0) begin
              out_valid <= 1'b1;
              state     <= S_OUT;
            end else begin
              x      <= wk.num;
              y      <= NumW'(wk.den);
              do_mod <= 1'b0;
              state  <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (!do_mod) begin
            if (y == '0) begin
              // x is the gcd: divide n by it
              y     <= x;
              rem   <= '0;
              quo   <= n;
              cnt   <= CntW'(NumW);
              state <= S_DIVN;
            end else begin
              rem    <= '0;
              quo    <= x;
              cnt    <= CntW'(NumW);
              do_mod <= 1'b1;
            end
          end else begin
            rem <= trial[NumW] ? rsh : trial[NumW-1:0];
            quo <= {quo[NumW-2:0], ~trial[NumW]};
            cnt <= cnt - 1'b1;
            if (cnt == CntW'(1)) begin
              x      <= y;
              y      <= trial[NumW] ? rsh : trial[NumW-1:0];
              do_mod <= 1'b0;
            end
          end
        end
        S_DIVN: begin
          if (cnt == CntW'(1)) begin
            out_item.result_num <= {quo[NumW-2:0], ~trial[NumW]};
            rem   <= '0;
            quo   <= d;
            cnt   <= CntW'(NumW);
            state <= S_DIVD;
          end else begin
            rem <= trial[NumW] ? rsh : trial[NumW-1:0];
            quo <= {quo[NumW-2:0], ~trial[NumW]};
            cnt <= cnt - 1'b1;
          end
        end
        S_DIVD: begin
          rem <= trial[NumW] ? rsh : trial[NumW-1:0];
          quo <= {quo[NumW-2:0], ~trial[NumW]};
          cnt <= cnt - 1'b1;
          if (cnt == CntW'(1)) begin
            out_item.result_den <= DenW'({quo[NumW-2:0], ~trial[NumW]});
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench: directed and random fraction transactions checked against a rational-math predictor.
module tb;
  import rau_pkg::*;

  localparam int OperandW  = 16;
  localparam int RandItems = 400;
  localparam int CycleCap  = 10000000;
  localparam int PauseAt   = 150;

  typedef struct packed {
    op_t                 operation;
    logic [OperandW-1:0] a_num;
    logic [OperandW-1:0] a_den;
    logic [OperandW-1:0] b_num;
    logic [OperandW-1:0] b_den;
  } in_item_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } vector_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  rational_arithmetic_unit #(.OPERAND_WIDTH(OperandW)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  out_item_t pending_results[$];
  vector_t   directed[$];
  int        mismatches;
  int        results_seen;
  int        zero_div_seen;
  int        cycles;
  int        phase;  // 0: sender idles less, 1: receiver idles less, 2: no idling

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic out_item_t fraction_result(in_item_t it);
    out_item_t   r;
    logic [63:0] an, ad, bn, bd, cross_a, cross_b, n, d, x, y, t;
    bit          arith;
    an = it.a_num; ad = it.a_den; bn = it.b_num; bd = it.b_den;
    cross_a = an * bd;
    cross_b = bn * ad;
    n = 0; d = 0; arith = 1'b1;
    r = '0;
    case (it.operation)
      OP_ADD: begin n = cross_a + cross_b; d = ad * bd; end
      OP_SUB: begin n = (cross_a > cross_b) ? cross_a - cross_b : 64'd0; d = ad * bd; end
      OP_MUL: begin n = an * bn; d = ad * bd; end
      OP_DIV: begin n = cross_a; d = ad * bn; end
      OP_EQ: begin arith = 1'b0; r.compare_true = (an == bn) && (ad == bd); end
      OP_GT: begin arith = 1'b0; r.compare_true = cross_a > cross_b; end
      OP_LT: begin arith = 1'b0; r.compare_true = cross_a < cross_b; end
      default: arith = 1'b0;
    endcase
    if (arith) begin
      if (d == 0) begin
        r.zero_divisor = 1'b1;
      end else if (n == 0) begin
        d = 1;
      end else begin
        x = n; y = d;
        while (y != 0) begin
          t = x % y; x = y; y = t;
        end
        n = n / x; d = d / x;
      end
      r.result_num = n[NumW-1:0];
      r.result_den = d[DenW-1:0];
    end
    return r;
  endfunction

  function automatic logic [OperandW-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return OperandW'($urandom);
      default: return OperandW'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.operation = op_t'(($urandom_range(0, 30) == 0) ? 7 : $urandom_range(0, 6));
    it.a_num = rand_operand();
    it.a_den = rand_operand();
    if ($urandom_range(0, 5) == 0) begin
      it.b_num = it.a_num;
      it.b_den = it.a_den;
    end else begin
      it.b_num = rand_operand();
      it.b_den = rand_operand();
    end
    return it;
  endfunction

  task automatic add_row(op_t op, int an, int ad, int bn, int bd, bit typed,
                         longint rn = 0, longint rd = 0, bit ct = 0, bit zd = 0);
    vector_t v;
    v.item = '{op, an[OperandW-1:0], ad[OperandW-1:0], bn[OperandW-1:0], bd[OperandW-1:0]};
    v.typed = typed;
    v.result = '{rn[NumW-1:0], rd[DenW-1:0], ct, zd};
    directed.push_back(v);
  endtask

  initial begin
    // zero numerator, zero denominator, underflow, unused code, extremes
    add_row(OP_ADD, 0, 3, 0, 5, 1, 0, 1, 0, 0);
    add_row(OP_ADD, 0, 0, 0, 7, 1, 0, 0, 0, 1);
    add_row(OP_SUB, 1, 2, 3, 4, 1, 0, 1, 0, 0);
    add_row(OP_SUB, 1, 0, 3, 4, 1, 4, 0, 0, 1);
    add_row(OP_NOP, 65535, 65535, 65535, 65535, 1, 0, 0, 0, 0);
    add_row(OP_MUL, 65535, 1, 65535, 1, 1, 64'd4294836225, 1, 0, 0);
    add_row(OP_ADD, 65535, 65535, 65535, 65535, 1, 2, 1, 0, 0);
    add_row(OP_ADD, 65535, 1, 65535, 1, 1, 131070, 1, 0, 0);
    add_row(OP_DIV, 1, 2, 0, 3, 1, 3, 0, 0, 1);
    add_row(OP_DIV, 65535, 1, 1, 65535, 1, 64'd4294836225, 1, 0, 0);
    add_row(OP_EQ, 3, 4, 3, 4, 1, 0, 0, 1, 0);
    add_row(OP_EQ, 1, 2, 2, 4, 1, 0, 0, 0, 0);
    add_row(OP_GT, 3, 4, 1, 2, 1, 0, 0, 1, 0);
    add_row(OP_LT, 3, 4, 1, 2, 1, 0, 0, 0, 0);
    add_row(OP_LT, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(OP_ADD, 1, 2, 1, 3, 0);
    add_row(OP_SUB, 3, 4, 1, 6, 0);
    add_row(OP_MUL, 6, 35, 14, 9, 0);
    add_row(OP_DIV, 7, 12, 21, 8, 0);
    add_row(OP_SUB, 65535, 1, 0, 65535, 0);
    add_row(OP_MUL, 0, 0, 65535, 65535, 0);
    add_row(OP_GT, 65535, 1, 65535, 2, 0);
    add_row(OP_ADD, 46368, 28657, 17711, 10946, 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      case (phase)
        0: out_stall <= $urandom_range(0, 99) < 63;
        1: out_stall <= $urandom_range(0, 99) < 29;
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (out_item.zero_divisor) zero_div_seen <= zero_div_seen + 1;
      if (pending_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = pending_results.pop_front();
        if (out_item !== want) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_item);
        end
      end
    end
  end

  initial begin
    int       total;
    int       sent;
    bit       idle;
    bit       took;
    vector_t  v;
    in_item_t next_item;
    mismatches = 0; results_seen = 0; zero_div_seen = 0; cycles = 0; phase = 0;
    rst = 1'b1; in_valid = 1'b0; in_item = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    total = directed.size() + RandItems;
    sent = 0;
    while (sent < total) begin
      @(posedge clk);
      took = in_valid && !in_stall;
      if (took) begin
        if (sent < directed.size() && directed[sent].typed)
          pending_results.push_back(directed[sent].result);
        else
          pending_results.push_back(fraction_result(in_item));
        sent++;
        phase = (sent * 3) / (total + 1);
      end
      if (took && sent == PauseAt) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end else if (!in_valid || took) begin
        case (phase)
          0: idle = $urandom_range(0, 99) < 29;
          1: idle = $urandom_range(0, 99) < 63;
          default: idle = 1'b0;
        endcase
        if (sent < total && !idle) begin
          if (sent < directed.size()) begin
            v = directed[sent];
            next_item = v.item;
          end else begin
            next_item = random_item();
          end
          in_item <= next_item;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    $display("covered %0d transactions (%0d directed) across all operations, %0d results",
             total, directed.size(), results_seen);
    $display("zero-denominator results: %0d, mismatches: %0d", zero_div_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
